### rtl/core/lkvc_pkg.sv
package lkvc_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam int unsigned LIMIT_W = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic latch_in;
    logic cmp_en;
    logic upd_en;
    logic out_load;
  } dp_cmd_t;

endpackage

### rtl/core/lru_key_value_cache_top.sv
// Fully associative LRU cache of key tags and data handles.
// Request channel (in_valid/in_ready): in_operation selects lookup,
// insert-or-update or remove for in_key_tag; in_data_in is stored on insert.
// Response channel (out_valid/out_ready): one response per request, with
// out_hit set when the key was present and out_data_out the stored handle on
// a lookup hit, zero otherwise.
// cfg_we writes cfg_wdata to the capacity limit (zero acts as one, values
// above CAPACITY act as CAPACITY); write it only while the cache is idle.
// Each request passes through parallel tag compare, recency and entry update
// with the data RAM read, and response register load before response valid.
// The sequencer handles one request at a time: a new request is taken only
// after the previous response has been loaded into the response register.
// The response register holds its contents while out_ready is low; the next
// request may be accepted meanwhile but its response waits for the slot.
// Reset empties the cache at once and sets the capacity limit to 100.
module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [KEY_W-1:0]   in_key_tag,
  input  logic [DATA_W-1:0]  in_data_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [DATA_W-1:0]  out_data_out,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkvc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_operation (in_operation),
    .in_key_tag   (in_key_tag),
    .in_data_in   (in_data_in),
    .out_hit      (out_hit),
    .out_data_out (out_data_out)
  );

endmodule

### rtl/core/lkvc_ram.sv
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lkvc_ctrl.sv
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_en = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/lkvc_datapath.sv
module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic [1:0]         in_operation,
  input  logic [KEY_W-1:0]   in_key_tag,
  input  logic [DATA_W-1:0]  in_data_in,
  output logic               out_hit,
  output logic [DATA_W-1:0]  out_data_out
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [LIMIT_W-1:0] limit_r;

  op_t               op_r;
  logic [KEY_W-1:0]  key_in_r;
  logic [DATA_W-1:0] data_in_r;

  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [KEY_W-1:0]    key_r [CAPACITY];
  logic [AW-1:0]       age_r [CAPACITY];
  logic [AW-1:0]       age_nxt [CAPACITY];
  logic [CAPACITY-1:0] key_we;
  logic [CW-1:0]       count_r, count_nxt;

  logic [CAPACITY-1:0] match, evict_oh, free_oh, vacant;
  logic [CAPACITY-1:0] match_r, evict_oh_r, free_oh_r, tgt_oh;
  logic                hit_r, evict_need_r, dsel_r;
  logic                evict_need;
  logic [CW-1:0]       cnt_m1;
  logic [LW-1:0]       limit_ext, eff_limit;

  logic [AW-1:0]       hit_idx, tgt_idx, age_s;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                out_hit_r;
  logic [DATA_W-1:0]   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r      <= in_operation;
      key_in_r  <= in_key_tag;
      data_in_r <= in_data_in;
    end
  end

  // compare stage: tags, eviction candidate, first vacant slot
  assign cnt_m1    = count_r - CW'(1);
  assign limit_ext = LW'(limit_r);
  assign vacant    = ~valid_r;
  assign free_oh   = vacant & (~vacant + CAPACITY'(1));

  always_comb begin
    eff_limit = limit_ext;
    if (limit_ext == '0) begin
      eff_limit = LW'(1);
    end else if (limit_ext > LW'(CAPACITY)) begin
      eff_limit = LW'(CAPACITY);
    end
  end

  assign evict_need = (LW'(count_r) >= eff_limit) && (count_r != '0);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]    = valid_r[i] && (key_r[i] == key_in_r);
      evict_oh[i] = valid_r[i] && (age_r[i] == cnt_m1[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      match_r      <= match;
      hit_r        <= |match;
      evict_oh_r   <= evict_oh;
      evict_need_r <= evict_need;
      free_oh_r    <= free_oh;
    end
  end

  // update stage
  assign tgt_oh = evict_need_r ? evict_oh_r : free_oh_r;

  always_comb begin
    hit_idx = '0;
    tgt_idx = '0;
    age_s   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | AW'(i);
        age_s   = age_s | age_r[i];
      end
      if (tgt_oh[i]) begin
        tgt_idx = tgt_idx | AW'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    count_nxt = count_r;
    key_we    = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = hit_idx;
    if (cmd.upd_en) begin
      case (op_r) inside
        OP_LOOKUP, OP_INSERT: begin
          if (hit_r) begin
            ram_re = (op_r == OP_LOOKUP);
            ram_we = (op_r == OP_INSERT);
            for (int i = 0; i < CAPACITY; i++) begin
              if (match_r[i]) begin
                age_nxt[i] = '0;
              end else if (valid_r[i] && (age_r[i] < age_s)) begin
                age_nxt[i] = age_r[i] + AW'(1);
              end
            end
          end else if (op_r == OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = tgt_idx;
            if (!evict_need_r) begin
              count_nxt = count_r + CW'(1);
            end
            for (int i = 0; i < CAPACITY; i++) begin
              if (tgt_oh[i]) begin
                valid_nxt[i] = 1'b1;
                key_we[i]    = 1'b1;
                age_nxt[i]   = '0;
              end else if (valid_r[i]) begin
                age_nxt[i] = age_r[i] + AW'(1);
              end
            end
          end
        end
        OP_REMOVE: begin
          if (hit_r) begin
            count_nxt = count_r - CW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (match_r[i]) begin
                valid_nxt[i] = 1'b0;
              end else if (valid_r[i] && (age_r[i] > age_s)) begin
                age_nxt[i] = age_r[i] - AW'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    age_r <= age_nxt;
    for (int i = 0; i < CAPACITY; i++) begin
      if (key_we[i]) begin
        key_r[i] <= key_in_r;
      end
    end
    if (cmd.upd_en) begin
      dsel_r <= (op_r == OP_LOOKUP) && hit_r;
    end
  end

  lkvc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_in_r),
    .re    (ram_re),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r  <= hit_r;
      out_data_r <= dsel_r ? ram_rdata : '0;
    end
  end

  assign out_hit      = out_hit_r;
  assign out_data_out = out_data_r;

endmodule

### tb/sv/tb_lru_key_value_cache_top.sv
`timescale 1ns / 100ps

module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  localparam int unsigned CACHE_DEPTH = 128;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } cache_req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } cache_rsp_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_operation = '0;
  logic [KEY_W-1:0]   in_key_tag = '0;
  logic [DATA_W-1:0]  in_data_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_hit;
  logic [DATA_W-1:0]  out_data_out;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  cache_req_t       req_backlog[$];
  cache_rsp_t       due_replies[$];
  logic [KEY_W-1:0] key_pool[$];

  logic              m_valid[CACHE_DEPTH];
  logic [KEY_W-1:0]  m_key[CACHE_DEPTH];
  logic [DATA_W-1:0] m_data[CACHE_DEPTH];
  int unsigned       m_age[CACHE_DEPTH];
  int unsigned       m_count;
  int unsigned       m_limit;

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [7:0]  stall_pat = 8'hFF;
  int unsigned stall_tick = 0;

  lru_key_value_cache_top #(
    .CAPACITY(CACHE_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_key_tag   (in_key_tag),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .out_data_out (out_data_out),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int slot_of(logic [KEY_W-1:0] k);
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (m_valid[i] && m_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void promote_slot(int s);
    int unsigned a;
    a = m_age[s];
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      if (m_valid[j] && m_age[j] < a) m_age[j]++;
    end
    m_age[s] = 0;
  endfunction

  function automatic void drop_slot(int s);
    int unsigned a;
    a = m_age[s];
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      if (m_valid[j] && m_age[j] > a) m_age[j]--;
    end
    m_valid[s] = 1'b0;
    if (m_count > 0) m_count--;
  endfunction

  function automatic void insert_key(logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
    int unsigned lim;
    int          free_slot;
    lim = (m_limit < 1) ? 1 : (m_limit > CACHE_DEPTH) ? CACHE_DEPTH : m_limit;
    free_slot = -1;
    if (m_count >= lim && m_count > 0) begin
      for (int j = 0; j < CACHE_DEPTH; j++) begin
        if (m_valid[j] && m_age[j] == m_count - 1) begin
          drop_slot(j);
          break;
        end
      end
    end
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      if (!m_valid[j]) begin
        free_slot = j;
        break;
      end
    end
    if (free_slot < 0) return;
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      if (m_valid[j]) m_age[j]++;
    end
    m_valid[free_slot] = 1'b1;
    m_key[free_slot]   = k;
    m_data[free_slot]  = d;
    m_age[free_slot]   = 0;
    m_count++;
  endfunction

  function automatic cache_rsp_t cache_access(cache_req_t r);
    cache_rsp_t rsp;
    int         s;
    s = slot_of(r.key);
    rsp.hit  = (s >= 0);
    rsp.data = '0;
    case (r.op)
      OP_LOOKUP: begin
        if (s >= 0) begin
          rsp.data = m_data[s];
          promote_slot(s);
        end
      end
      OP_INSERT: begin
        if (s >= 0) begin
          m_data[s] = r.data;
          promote_slot(s);
        end else begin
          insert_key(r.key, r.data);
        end
      end
      OP_REMOVE: begin
        if (s >= 0) drop_slot(s);
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // drive requests on the falling edge
  always @(negedge clk) begin
    cache_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until taken
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (req_backlog.size() > 0) begin
      r = req_backlog[0];
      req_backlog.delete(0);
      in_operation <= r.op;
      in_key_tag   <= r.key;
      in_data_in   <= r.data;
      in_valid     <= 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_tick == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    stall_tick = (stall_tick + 1) % 32;
    out_ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[7:1]};
  end

  always @(posedge clk) begin
    cache_rsp_t got;
    cache_rsp_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.hit  = out_hit;
        got.data = out_data_out;
        if (due_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response hit=%b data=%h", $time, got.hit, got.data);
        end else begin
          want = due_replies[0];
          due_replies.delete(0);
          if (got.hit !== want.hit) begin
            fail_count++;
            $display("%0t: hit mismatch expected %b actual %b", $time, want.hit, got.hit);
          end
          if (got.data !== want.data) begin
            fail_count++;
            $display("%0t: data_out mismatch expected %h actual %h",
                     $time, want.data, got.data);
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        due_replies.insert(due_replies.size(),
                           cache_access(cache_req_t'{in_operation, in_key_tag, in_data_in}));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("lru_key_value_cache_top verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_req(op_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
    req_backlog.insert(req_backlog.size(), cache_req_t'{op, k, d});
  endtask

  task automatic wait_idle();
    while (req_backlog.size() > 0 || in_valid || due_replies.size() > 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    m_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n, int pool_n);
    op_t              op;
    logic [KEY_W-1:0] k;
    int unsigned      roll;
    if (pool_n > 0) begin
      key_pool.delete();
      repeat (pool_n) key_pool.insert(key_pool.size(), fresh_key());
    end
    repeat (n) begin
      roll = $urandom_range(0, 99);
      op = (roll < 40) ? OP_INSERT : (roll < 80) ? OP_LOOKUP :
           (roll < 95) ? OP_REMOVE : OP_UNUSED;
      if ($urandom_range(0, 9) == 0) k = fresh_key();
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      push_req(op, k, $urandom);
    end
  endtask

  task automatic fill_distinct(int n);
    logic [KEY_W-1:0] k;
    key_pool.delete();
    repeat (n) begin
      k = fresh_key();
      key_pool.insert(key_pool.size(), k);
      push_req(OP_INSERT, k, $urandom);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k_lo;
    logic [KEY_W-1:0] k_hi;
    logic [KEY_W-1:0] k_a;
    logic [KEY_W-1:0] k_b;
    k_lo = '0;
    k_hi = '1;
    k_a  = 64'h0123_4567_89AB_CDEF;
    k_b  = 64'hFEDC_BA98_7654_3210;
    for (int i = 0; i < CACHE_DEPTH; i++) m_valid[i] = 1'b0;
    m_count = 0;
    m_limit = LIMIT_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_req(OP_LOOKUP, k_lo, '1);
    push_req(OP_REMOVE, k_lo, '0);
    push_req(OP_UNUSED, k_lo, '1);
    push_req(OP_INSERT, k_lo, '0);
    push_req(OP_INSERT, k_hi, '1);
    push_req(OP_LOOKUP, k_lo, '0);
    push_req(OP_LOOKUP, k_hi, '0);
    push_req(OP_INSERT, k_lo, 32'hA5A5_A5A5);
    push_req(OP_LOOKUP, k_lo, '0);
    push_req(OP_UNUSED, k_hi, '1);
    push_req(OP_INSERT, k_a, 32'h5A5A_5A5A);
    push_req(OP_REMOVE, k_hi, '0);
    push_req(OP_LOOKUP, k_hi, '0);
    push_req(OP_REMOVE, k_hi, '0);
    push_req(OP_INSERT, k_hi, 32'h1234_5678);
    push_req(OP_LOOKUP, k_a, '0);

    // zero limit acts as one, and sits below the current count
    write_limit(8'd0);
    push_req(OP_INSERT, k_b, 32'hDEAD_BEEF);
    push_req(OP_LOOKUP, k_a, '0);
    push_req(OP_INSERT, k_a, 32'hCAFE_F00D);
    push_req(OP_LOOKUP, k_b, '0);
    push_req(OP_LOOKUP, k_a, '0);
    push_req(OP_REMOVE, k_a, '0);
    push_req(OP_LOOKUP, k_a, '0);

    write_limit(8'd3);
    random_phase(60, 8);
    write_limit(8'd1);
    random_phase(30, 4);

    // above the depth: saturate, then evict once full
    write_limit(8'd255);
    fill_distinct(150);
    random_phase(40, 0);

    write_limit(8'd40);
    random_phase(60, 30);
    write_limit(8'd5);
    random_phase(60, 40);
    write_limit(8'd128);
    random_phase(40, 16);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("lru_key_value_cache_top verification clean");
    end else begin
      $display("lru_key_value_cache_top verification failed");
    end
    $finish;
  end

endmodule
